// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files of the block buffer cache
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define LBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define LBC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lbc_pkg.sv =====
// types and constants of the block buffer cache
// no dependencies; used by lbc_entry_mem, lbc_ctrl and the top level
`timescale 1ns / 1ps
`default_nettype none
package lbc_pkg;

    localparam int IDX_W  = 6;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int REFS_W = 8;
    localparam int RANK_W = 6;
    localparam int STAT_W = 2;

    localparam logic [REFS_W-1:0] REFS_MAX = 8'hFF;

    // request modes
    localparam logic MODE_GET     = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_RELEASE = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW    = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block_number;
        logic [IDX_W-1:0]  release_index;
    } lbc_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  entry_index;
        logic              hit;
        logic              needs_fill;
        logic [STAT_W-1:0] status;
    } lbc_out_t;

    // one tag store record
    typedef struct packed {
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block;
        logic              tag_valid;
        logic              data_valid;
        logic [REFS_W-1:0] refs;
        logic [RANK_W-1:0] rank;
    } entry_t;

    // tag store access from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        entry_t            wr_data;
    } mem_req_t;

endpackage
`default_nettype wire

// ===== sv/lbc_entry_mem.sv =====
// tag store memory: one record per buffer, one read and one write port
// depends on lbc_pkg; entries never written read back as their reset value
`timescale 1ns / 1ps
`default_nettype none
module lbc_entry_mem #(
    parameter int BUFFERS = 32
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  lbc_pkg::mem_req_t req,
    output lbc_pkg::entry_t   rd_data
);
    import lbc_pkg::*;

    localparam int AW = $clog2(BUFFERS);
    localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(BUFFERS - 1);

    entry_t                entry_mem [BUFFERS];
    entry_t                mem_q_reg;
    logic [IDX_W-1:0]      idx_q_reg;
    logic                  init_q_reg;
    logic [BUFFERS-1:0]    init_reg;

    // memory array with registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            entry_mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en) begin
            mem_q_reg <= entry_mem[req.rd_addr[AW-1:0]];
            idx_q_reg <= req.rd_addr;
        end
    end

    // per-entry written flags, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg   <= '0;
            init_q_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                init_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (req.rd_en) begin
                init_q_reg <= init_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    // substitute the reset record for entries not yet written
    always_comb begin
        if (init_q_reg) begin
            rd_data = mem_q_reg;
        end else begin
            rd_data      = '0;
            rd_data.rank = LAST_RANK - idx_q_reg;
        end
    end

endmodule
`default_nettype wire

// ===== sv/lbc_ctrl.sv =====
// request sequencer: hit and victim scan, refcount update, recency rescan
// depends on lbc_pkg; drives the tag store through a mem_req_t
`timescale 1ns / 1ps
`default_nettype none
module lbc_ctrl #(
    parameter int BUFFERS = 32
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  lbc_pkg::lbc_in_t   s_data,
    output logic               res_valid,
    input  wire                res_ready,
    output lbc_pkg::lbc_out_t  res_data,
    output lbc_pkg::mem_req_t  mem_req,
    input  lbc_pkg::entry_t    mem_rd
);
    import lbc_pkg::*;

    localparam int CW = $clog2(BUFFERS + 1);
    localparam logic [CW-1:0]    NBUF   = CW'(BUFFERS);
    localparam logic [IDX_W:0]   NBUF_X = (IDX_W + 1)'(BUFFERS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_GSCAN  = 7'b0000010,
        S_GWRITE = 7'b0000100,
        S_RREAD  = 7'b0001000,
        S_RCHECK = 7'b0010000,
        S_RSCAN  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    lbc_in_t           req_reg, req_next;
    logic [CW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  didx_reg, didx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    entry_t            found_ent_reg, found_ent_next;
    logic              victim_reg, victim_next;
    logic [IDX_W-1:0]  victim_idx_reg, victim_idx_next;
    entry_t            victim_ent_reg, victim_ent_next;
    logic [RANK_W-1:0] rel_rank_reg, rel_rank_next;
    lbc_out_t          res_reg, res_next;

    logic              issue;
    logic              match;
    entry_t            wr_ent;

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_data  = res_reg;
    assign issue     = (rd_cnt_reg != NBUF);
    assign match     = mem_rd.tag_valid && (mem_rd.device == req_reg.device)
                       && (mem_rd.block == req_reg.block_number);

    // sequencer next state and memory access
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = pend_reg;
        didx_next       = didx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_ent_next  = found_ent_reg;
        victim_next     = victim_reg;
        victim_idx_next = victim_idx_reg;
        victim_ent_next = victim_ent_reg;
        rel_rank_next   = rel_rank_reg;
        res_next        = res_reg;
        mem_req         = '0;
        wr_ent          = mem_rd;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    if (s_data.mode == MODE_GET) begin
                        rd_cnt_next = '0;
                        pend_next   = 1'b0;
                        found_next  = 1'b0;
                        victim_next = 1'b0;
                        state_next  = S_GSCAN;
                    end else if ({1'b0, s_data.release_index} >= NBUF_X) begin
                        res_next   = '{entry_index: s_data.release_index, hit: 1'b0,
                                       needs_fill: 1'b0, status: ST_BAD_RELEASE};
                        state_next = S_DONE;
                    end else begin
                        state_next = S_RREAD;
                    end
                end
            end

            // one record per cycle: lowest-rank match, highest-rank free entry
            S_GSCAN: begin
                if (issue) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(rd_cnt_reg);
                    rd_cnt_next     = rd_cnt_reg + 1'b1;
                end
                pend_next = issue;
                didx_next = IDX_W'(rd_cnt_reg);
                if (pend_reg) begin
                    if (match && (!found_reg || (mem_rd.rank < found_ent_reg.rank))) begin
                        found_next     = 1'b1;
                        found_idx_next = didx_reg;
                        found_ent_next = mem_rd;
                    end
                    if ((mem_rd.refs == '0)
                        && (!victim_reg || (mem_rd.rank > victim_ent_reg.rank))) begin
                        victim_next     = 1'b1;
                        victim_idx_next = didx_reg;
                        victim_ent_next = mem_rd;
                    end
                    if (!issue) begin
                        state_next = S_GWRITE;
                    end
                end
            end

            // write back the hit or the claimed victim, else report no free entry
            S_GWRITE: begin
                state_next = S_DONE;
                if (found_reg) begin
                    wr_ent            = found_ent_reg;
                    wr_ent.data_valid = 1'b1;
                    res_next = '{entry_index: found_idx_reg, hit: 1'b1,
                                 needs_fill: !found_ent_reg.data_valid, status: ST_OK};
                    if (found_ent_reg.refs == REFS_MAX) begin
                        res_next.status = ST_OVERFLOW;
                    end else begin
                        wr_ent.refs = found_ent_reg.refs + 1'b1;
                    end
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = found_idx_reg;
                    mem_req.wr_data = wr_ent;
                end else if (victim_reg) begin
                    wr_ent            = victim_ent_reg;
                    wr_ent.device     = req_reg.device;
                    wr_ent.block      = req_reg.block_number;
                    wr_ent.tag_valid  = 1'b1;
                    wr_ent.data_valid = 1'b1;
                    wr_ent.refs       = REFS_W'(1);
                    mem_req.wr_en     = 1'b1;
                    mem_req.wr_addr   = victim_idx_reg;
                    mem_req.wr_data   = wr_ent;
                    res_next = '{entry_index: victim_idx_reg, hit: 1'b0,
                                 needs_fill: 1'b1, status: ST_OK};
                end else begin
                    res_next = '{entry_index: '0, hit: 1'b0,
                                 needs_fill: 1'b0, status: ST_NO_FREE};
                end
            end

            S_RREAD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = req_reg.release_index;
                state_next      = S_RCHECK;
            end

            // reject a zero count, decrement, or start the recency rescan when the count drops to zero
            S_RCHECK: begin
                res_next = '{entry_index: req_reg.release_index, hit: 1'b0,
                             needs_fill: 1'b0, status: ST_OK};
                if (mem_rd.refs == '0) begin
                    res_next.status = ST_BAD_RELEASE;
                    state_next      = S_DONE;
                end else if (mem_rd.refs != REFS_W'(1)) begin
                    wr_ent.refs     = mem_rd.refs - 1'b1;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = req_reg.release_index;
                    mem_req.wr_data = wr_ent;
                    state_next      = S_DONE;
                end else begin
                    rel_rank_next = mem_rd.rank;
                    rd_cnt_next   = '0;
                    pend_next     = 1'b0;
                    state_next    = S_RSCAN;
                end
            end

            // age entries more recent than the released one, released goes to front
            S_RSCAN: begin
                if (issue) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(rd_cnt_reg);
                    rd_cnt_next     = rd_cnt_reg + 1'b1;
                end
                pend_next = issue;
                didx_next = IDX_W'(rd_cnt_reg);
                if (pend_reg) begin
                    mem_req.wr_addr = didx_reg;
                    if (didx_reg == req_reg.release_index) begin
                        wr_ent.refs   = '0;
                        wr_ent.rank   = '0;
                        mem_req.wr_en = 1'b1;
                    end else if (mem_rd.rank < rel_rank_reg) begin
                        wr_ent.rank   = mem_rd.rank + 1'b1;
                        mem_req.wr_en = 1'b1;
                    end
                    mem_req.wr_data = wr_ent;
                    if (!issue) begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            victim_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            victim_reg <= victim_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        rd_cnt_reg     <= rd_cnt_next;
        didx_reg       <= didx_next;
        found_idx_reg  <= found_idx_next;
        found_ent_reg  <= found_ent_next;
        victim_idx_reg <= victim_idx_next;
        victim_ent_reg <= victim_ent_next;
        rel_rank_reg   <= rel_rank_next;
        res_reg        <= res_next;
    end

endmodule
`default_nettype wire

// ===== sv/lru_block_buffer_cache.sv =====
// Block buffer cache tag store with reference counts and LRU replacement.
// Input channel s_*: one transfer per request, s_data.mode selects get or
// release. Output channel m_*: exactly one result transfer per request.
// Requests are handled one at a time; s_ready is high only while the
// sequencer is idle, and the next request is taken while a finished result
// still waits in the output register.
// Tag store work, acceptance to m_valid:
//   get                    full scan, then write-back of the hit or the victim
//   release, count stays   read, then write of the entry; index out of range: no access
//   release, count to zero read, then full rescan
// The tag store has one read port and yields one record per cycle; it is
// scanned in full for each get and for each release that frees an entry.
// Reset: all entries untagged with count zero, entry i at recency rank
// BUFFERS-1-i; a per-entry written flag supplies that without a clear pass.
// When m_ready is low the result holds in the output register and the
// sequencer waits with the following result until the register frees up.
// depends on lbc_pkg, lbc_entry_mem, lbc_ctrl and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lru_block_buffer_cache #(
    parameter int BUFFERS = 32
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  lbc_pkg::lbc_in_t   s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output lbc_pkg::lbc_out_t  m_data
);
    import lbc_pkg::*;

    mem_req_t  mem_req;
    entry_t    mem_rd;
    logic      res_valid;
    logic      res_ready;
    lbc_out_t  res_data;
    logic      m_valid_reg;
    lbc_out_t  m_data_reg;

    lbc_entry_mem #(.BUFFERS(BUFFERS)) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    lbc_ctrl #(.BUFFERS(BUFFERS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_req   (mem_req),
        .mem_rd    (mem_rd)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    // checks
    `LBC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `LBC_ASSERT_NEXT(a_result_held, aclk, aresetn, res_valid && !res_ready, res_valid)
    `LBC_ASSERT_IMPL(a_no_free_shape, aclk, aresetn,
        m_valid && (m_data.status == ST_NO_FREE),
        !m_data.hit && !m_data.needs_fill && (m_data.entry_index == '0))
    `LBC_ASSERT_IMPL(a_hit_status, aclk, aresetn, m_valid && m_data.hit,
        (m_data.status == ST_OK) || (m_data.status == ST_OVERFLOW))

endmodule
`default_nettype wire
